/* src/lkvc_pkg.sv */
// shared constants and types of the lru key-value cache
package lkvc_pkg;

	localparam int DEFAULT_ENTRIES = 16;
	localparam int DATA_W          = 32;
	localparam int CAP_W           = 5;

	localparam logic [CAP_W-1:0]  CAP_RESET  = CAP_W'(16);
	localparam logic [DATA_W-1:0] MISS_VALUE = '1;
	localparam logic [DATA_W-1:0] PUT_VALUE  = '0;

	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

endpackage

/* src/lru_key_value_cache_core.sv */
// fully associative key-value cache with least-recently-used replacement
//
// Usage:
//   request channel (req_valid/req_stall) carries one word: command, key, value.
//   command get looks up key; put inserts or overwrites key with value.
//   response channel (rsp_valid/rsp_stall) returns one word per request:
//   hit, read_value (stored value on get hit, all ones on get miss, zero on
//   put) and evicted (a put of a new key removed the least recent entries).
//   A request passes through one request register, then a single pass of
//   parallel key compare, rank update and eviction into the response
//   register. One request per cycle is sustained while rsp_stall is low;
//   the rate is set by that single compare-and-update pass over all entries.
//   rsp_stall holds the response register; req_stall rises only while both
//   the request and response registers are occupied and the response stalls.
//   cfg_we/cfg_wdata writes the capacity (0 acts as 1, above ENTRIES acts as
//   ENTRIES); write it only while no request is in flight.
//   After reset the cache is empty and the capacity is 16.
module lru_key_value_cache_core #(
	parameter int ENTRIES = lkvc_pkg::DEFAULT_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0]     cfg_wdata,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic                           command,
	input  logic signed [lkvc_pkg::DATA_W-1:0] key,
	input  logic signed [lkvc_pkg::DATA_W-1:0] value,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic                           hit,
	output logic signed [lkvc_pkg::DATA_W-1:0] read_value,
	output logic                           evicted
);
	import lkvc_pkg::*;

	localparam int RW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// request register
	logic              valid_s1;
	cmd_t              command_s1;
	logic [DATA_W-1:0] key_s1;
	logic [DATA_W-1:0] value_s1;

	// response register
	logic              rsp_valid_q;
	logic              hit_q;
	logic [DATA_W-1:0] read_value_q;
	logic              evicted_q;

	// cache state
	logic [DATA_W-1:0] keys_q   [ENTRIES];
	logic [DATA_W-1:0] values_q [ENTRIES];
	logic [RW-1:0]     rank_q   [ENTRIES];
	logic [ENTRIES-1:0] valid_q;
	logic [CNT_W-1:0]  occ_q;
	logic [CAP_W-1:0]  cap_q;

	logic               advance;
	logic               accept;
	logic [CNT_W-1:0]   cap_eff;
	logic [ENTRIES-1:0] match;
	logic               found;
	logic [RW-1:0]      slot;
	logic [RW-1:0]      slot_rank;
	logic               is_put;
	logic               need_evict;
	logic [ENTRIES-1:0] evict_mask;
	logic [ENTRIES-1:0] valid_kept;
	logic [RW-1:0]      free_slot;
	logic [CNT_W-1:0]   occ_kept;

	logic [RW-1:0]      rank_d  [ENTRIES];
	logic [ENTRIES-1:0] valid_d;
	logic [CNT_W-1:0]   occ_d;
	logic               wr_en;
	logic [RW-1:0]      wr_slot;
	logic               wr_key;
	logic [DATA_W-1:0]  rsp_value_d;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign accept    = req_valid && !req_stall;
	assign req_stall = valid_s1 && !advance;

	assign rsp_valid  = rsp_valid_q;
	assign hit        = hit_q;
	assign read_value = read_value_q;
	assign evicted    = evicted_q;

	assign is_put = (command_s1 == CMD_PUT);

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (int'(cap_q) > ENTRIES) begin
			cap_eff = CNT_W'(ENTRIES);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	// parallel key compare
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (keys_q[i] == key_s1);
		end
		found = |match;
		slot  = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (match[i]) begin
				slot = RW'(i);
			end
		end
		slot_rank = rank_q[slot];
	end

	// eviction of every entry at or past the capacity boundary
	always_comb begin
		need_evict = is_put && !found && (occ_q >= cap_eff);
		for (int i = 0; i < ENTRIES; i++) begin
			evict_mask[i] = need_evict && valid_q[i] &&
				(CNT_W'(rank_q[i]) >= (cap_eff - CNT_W'(1)));
		end
		valid_kept = valid_q & ~evict_mask;
		occ_kept   = need_evict ? (cap_eff - CNT_W'(1)) : occ_q;
		free_slot  = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!valid_kept[i]) begin
				free_slot = RW'(i);
			end
		end
	end

	// next state
	always_comb begin
		rank_d      = rank_q;
		valid_d     = valid_q;
		occ_d       = occ_q;
		wr_en       = 1'b0;
		wr_key      = 1'b0;
		wr_slot     = slot;
		rsp_value_d = PUT_VALUE;
		if (found) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (valid_q[i] && (rank_q[i] < slot_rank)) begin
					rank_d[i] = rank_q[i] + RW'(1);
				end
			end
			rank_d[slot] = '0;
			wr_en        = is_put;
			if (!is_put) begin
				rsp_value_d = values_q[slot];
			end
		end else if (is_put) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (evict_mask[i]) begin
					rank_d[i] = '0;
				end else if (valid_kept[i]) begin
					rank_d[i] = rank_q[i] + RW'(1);
				end
			end
			valid_d            = valid_kept;
			valid_d[free_slot] = 1'b1;
			rank_d[free_slot]  = '0;
			occ_d              = occ_kept + CNT_W'(1);
			wr_en              = 1'b1;
			wr_key             = 1'b1;
			wr_slot            = free_slot;
		end else begin
			rsp_value_d = MISS_VALUE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			command_s1 <= cmd_t'(command);
			key_s1     <= key;
			value_s1   <= value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q        <= found;
			read_value_q <= rsp_value_d;
			evicted_q    <= need_evict;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (advance) begin
			valid_q <= valid_d;
			occ_q   <= occ_d;
			rank_q  <= rank_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && wr_en) begin
			values_q[wr_slot] <= value_s1;
			if (wr_key) begin
				keys_q[wr_slot] <= key_s1;
			end
		end
	end

	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'($countones(valid_q)) == occ_q)
		else $error("occupancy count differs from valid entries");

	a_occ_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= ENTRIES)
		else $error("occupancy above entry count");

	a_evict_fills_to_cap: assert property (@(posedge clk) disable iff (!arst_n)
		advance && need_evict |=> occ_q == $past(cap_eff))
		else $error("eviction left wrong occupancy");

	a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && evicted_q |-> !hit_q && read_value_q == PUT_VALUE)
		else $error("eviction reported on hit or get");

endmodule
